@@ design/fixed_partition_placement_engine_unit_macros.svh @@
// assertion macros for the placement engine checker
// no dependencies; include by bare file name
`ifndef FIXED_PARTITION_PLACEMENT_ENGINE_UNIT_MACROS_SVH
`define FIXED_PARTITION_PLACEMENT_ENGINE_UNIT_MACROS_SVH

// clocked property, masked while reset is high
`define FPPE_ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked property that also holds across reset
`define FPPE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/fppe_pkg.sv @@
// shared types and constants for the fixed partition placement engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fppe_pkg;

   localparam int BLOCKS_DEF    = 16;
   localparam int SIZE_BITS_DEF = 16;

   localparam int KIND_W   = 2;
   localparam int SLOT_W   = 4;
   localparam int AMOUNT_W = 16;
   localparam int NUM_W    = 4;
   localparam int CFG_W    = 5;
   localparam int POL_W    = 2;
   localparam int IN_DATA_W  = 24;
   localparam int OUT_DATA_W = 24;

   // input item kinds
   localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

   // register indexes
   localparam logic CSR_POLICY = 1'b0;
   localparam logic CSR_BLOCKS = 1'b1;

   localparam logic [CFG_W-1:0] BLOCKS_IN_USE_RST = 5'd16;

   typedef enum logic [POL_W-1:0] {
      POL_FIRST = 2'd0,
      POL_NEXT  = 2'd1,
      POL_BEST  = 2'd2,
      POL_WORST = 2'd3
   } policy_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_COMMIT
   } state_type;

   // control from the sequencer to the pick unit
   typedef struct packed {
      logic       clear;
      logic       eval;
      logic       cand_taken;
      policy_type policy;
   } pick_ctl_type;

endpackage

`default_nettype wire

@@ design/fppe_pick.sv @@
// pick unit: fit and ranking compare, holds the best candidate so far
// depends on fppe_pkg
`timescale 1ns / 1ps
`default_nettype none

module fppe_pick
   import fppe_pkg::*;
#(
   parameter int BLOCKS    = BLOCKS_DEF,
   parameter int SIZE_BITS = SIZE_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pick_ctl_type                 ctl,
   input  wire logic [$clog2(BLOCKS)-1:0]    cand_pos,
   input  wire logic [SIZE_BITS-1:0]         cand_size,
   input  wire logic [AMOUNT_W-1:0]          demand,
   output logic                              found,
   output logic [$clog2(BLOCKS)-1:0]         best_pos,
   output logic [SIZE_BITS-1:0]              best_size
);

   localparam int IDX_W = $clog2(BLOCKS);
   localparam int CMP_W = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic                 fit;
   logic                 better;

   always_comb begin
      fit    = !ctl.cand_taken && (CMP_W'(cand_size) >= CMP_W'(demand));
      better = 1'b0;
      if (!found_ff) begin
         better = 1'b1;
      end else begin
         unique case (ctl.policy)
            POL_BEST:  better = cand_size < size_ff;
            POL_WORST: better = cand_size > size_ff;
            POL_FIRST,
            POL_NEXT:  better = 1'b0;
            default:   better = 1'b0;
         endcase
      end

      found_in = found_ff;
      pos_in   = pos_ff;
      size_in  = size_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (ctl.eval && fit && better) begin
         found_in = 1'b1;
         pos_in   = cand_pos;
         size_in  = cand_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      pos_ff  <= pos_in;
      size_ff <= size_in;
   end

   assign found     = found_ff;
   assign best_pos  = pos_ff;
   assign best_size = size_ff;

endmodule

`default_nettype wire

@@ design/fixed_partition_placement_engine_unit.sv @@
// top level of the fixed partition placement engine: sequencer, size memory, marks
// depends on fppe_pkg and fppe_pick
`timescale 1ns / 1ps
`default_nettype none

// Placement engine over a table of BLOCKS fixed blocks (size plus taken mark).
// Every input transfer yields exactly one result transfer. A load (tuser kind 0)
// writes one block size and frees the block; a restart (kind 2) frees all blocks
// and clears the next-fit pointer; both answer in the next cycle with all zero.
// A request (kind 1) walks the blocks in use through the single read port of the
// size memory, one block per cycle, and a shared compare unit keeps the best
// candidate for the policy (first, next, best, worst fit; ties to the lowest
// position, next fit starting at the pointer and wrapping). A request passes
// through an accept step, a read of each block in use, a step for the read
// latency and a commit step that waits until the result slot is free.
// The input is not ready while a request is in flight, nor while a finished result
// waits and cannot be replaced. Configuration must be written only while idle;
// a write is not held off during a scan.
// Reset clears marks, size-valid bits and the pointer at once; no clearing pass.

module fixed_partition_placement_engine_unit
   import fppe_pkg::*;
#(
   parameter int BLOCKS    = BLOCKS_DEF,
   parameter int SIZE_BITS = SIZE_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [IN_DATA_W-1:0]    req_tdata,   // block_slot[3:0], amount[19:4], zero
   input  wire logic [KIND_W-1:0]       req_tuser,   // kind[1:0]
   // result channel
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [OUT_DATA_W-1:0]        rsp_tdata,   // block_number[3:0], block_size[19:4], zero
   output logic                         rsp_tuser,   // granted[0]
   // register write port
   input  wire logic                    csr_we,
   input  wire logic                    csr_index,
   input  wire logic [CFG_W-1:0]        csr_wdata
);

   localparam int IDX_W = $clog2(BLOCKS);
   localparam int CNT_W = $clog2(BLOCKS + 1);

   // request payload fields
   logic [SLOT_W-1:0]   req_slot;
   logic [AMOUNT_W-1:0] req_amount;
   assign req_slot   = req_tdata[SLOT_W-1:0];
   assign req_amount = req_tdata[SLOT_W +: AMOUNT_W];

   // configuration
   policy_type       policy_ff;
   logic [CFG_W-1:0] blocks_cfg_ff;

   // sequencer and scan state
   state_type           state_ff, state_in;
   logic [AMOUNT_W-1:0] demand_ff, demand_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [CNT_W-1:0]    step_ff, step_in;
   logic [IDX_W-1:0]    addr_ff, addr_in;
   logic [IDX_W-1:0]    eval_pos_ff, eval_pos_in;
   logic                eval_vld_ff, eval_vld_in;

   // block table
   logic [SIZE_BITS-1:0] size_mem [BLOCKS];
   logic [SIZE_BITS-1:0] rd_q_ff;
   logic [BLOCKS-1:0]    size_vld_ff;
   logic [BLOCKS-1:0]    taken_ff;
   logic [IDX_W-1:0]     next_start_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_granted_ff, rsp_granted_in;
   logic [NUM_W-1:0]     rsp_num_ff, rsp_num_in;
   logic [AMOUNT_W-1:0]  rsp_size_ff, rsp_size_in;

   // decoded controls
   logic                 out_free;
   logic                 accept;
   logic                 slot_ok;
   logic [IDX_W-1:0]     slot_idx;
   logic [CNT_W-1:0]     n_eff;
   logic [IDX_W-1:0]     scan_start;
   logic [CNT_W-1:0]     addr_inc;
   logic [CNT_W-1:0]     pick_inc;
   logic                 do_load;
   logic                 do_restart;
   logic                 do_commit;
   logic                 rd_en;
   logic [SIZE_BITS-1:0] cand_size;

   // pick unit hookup
   pick_ctl_type         pick_ctl;
   logic                 pick_found;
   logic [IDX_W-1:0]     pick_pos;
   logic [SIZE_BITS-1:0] pick_size;

   // result slot can be (re)loaded when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   assign slot_ok  = 32'(req_slot) < BLOCKS;
   assign slot_idx = IDX_W'(req_slot);

   // effective block count, clamped to the table
   assign n_eff = (32'(blocks_cfg_ff) > BLOCKS) ? CNT_W'(BLOCKS) : CNT_W'(blocks_cfg_ff);

   // next fit starts at the pointer unless it sits outside the blocks in use
   assign scan_start = ((policy_ff == POL_NEXT) && (CNT_W'(next_start_ff) < n_eff))
                       ? next_start_ff : '0;

   assign addr_inc = CNT_W'(addr_ff) + CNT_W'(1);
   assign pick_inc = CNT_W'(pick_pos) + CNT_W'(1);

   // entries never loaded read as size zero
   assign cand_size = size_vld_ff[eval_pos_ff] ? rd_q_ff : '0;

   assign pick_ctl.clear      = accept;
   assign pick_ctl.eval       = eval_vld_ff;
   assign pick_ctl.cand_taken = taken_ff[eval_pos_ff];
   assign pick_ctl.policy     = policy_ff;

   always_comb begin
      state_in       = state_ff;
      demand_in      = demand_ff;
      n_in           = n_ff;
      step_in        = step_ff;
      addr_in        = addr_ff;
      eval_pos_in    = addr_ff;
      eval_vld_in    = 1'b0;
      rsp_valid_in   = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_num_in     = rsp_num_ff;
      rsp_size_in    = rsp_size_ff;
      do_load        = 1'b0;
      do_restart     = 1'b0;
      do_commit      = 1'b0;
      rd_en          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == KIND_REQUEST) begin
                  demand_in = req_amount;
                  n_in      = n_eff;
                  step_in   = '0;
                  addr_in   = scan_start;
                  // nothing to scan with zero blocks in use
                  state_in  = (n_eff == '0) ? ST_COMMIT : ST_SCAN;
               end else begin
                  // load, restart and the unused kind answer at once, all zero
                  do_load        = (req_tuser == KIND_LOAD) && slot_ok;
                  do_restart     = req_tuser == KIND_RESTART;
                  rsp_valid_in   = 1'b1;
                  rsp_granted_in = 1'b0;
                  rsp_num_in     = '0;
                  rsp_size_in    = '0;
               end
            end
         end
         ST_SCAN: begin
            // one table read a cycle, compared in the next cycle
            rd_en       = 1'b1;
            eval_vld_in = 1'b1;
            eval_pos_in = addr_ff;
            addr_in     = (addr_inc == n_ff) ? '0 : IDX_W'(addr_inc);
            step_in     = step_ff + CNT_W'(1);
            if (step_in == n_ff) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            // last read lands in the pick unit on this edge
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               do_commit      = pick_found;
               rsp_valid_in   = 1'b1;
               rsp_granted_in = pick_found;
               rsp_num_in     = pick_found ? NUM_W'(pick_pos) : '0;
               rsp_size_in    = pick_found ? AMOUNT_W'(pick_size) : '0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         eval_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         policy_ff     <= POL_FIRST;
         blocks_cfg_ff <= BLOCKS_IN_USE_RST;
         size_vld_ff   <= '0;
         taken_ff      <= '0;
         next_start_ff <= '0;
      end else begin
         state_ff     <= state_in;
         eval_vld_ff  <= eval_vld_in;
         rsp_valid_ff <= rsp_valid_in;

         if (csr_we) begin
            priority case (csr_index)
               CSR_POLICY: policy_ff     <= policy_type'(csr_wdata[POL_W-1:0]);
               CSR_BLOCKS: blocks_cfg_ff <= csr_wdata;
               default:    blocks_cfg_ff <= blocks_cfg_ff;
            endcase
         end

         if (do_load) begin
            size_vld_ff[slot_idx] <= 1'b1;
            taken_ff[slot_idx]    <= 1'b0;
         end
         if (do_restart) begin
            taken_ff      <= '0;
            next_start_ff <= '0;
         end
         if (do_commit) begin
            taken_ff[pick_pos] <= 1'b1;
            if (policy_ff == POL_NEXT) begin
               next_start_ff <= (pick_inc >= n_ff) ? '0 : IDX_W'(pick_inc);
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      demand_ff      <= demand_in;
      n_ff           <= n_in;
      step_ff        <= step_in;
      addr_ff        <= addr_in;
      eval_pos_ff    <= eval_pos_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_num_ff     <= rsp_num_in;
      rsp_size_ff    <= rsp_size_in;
   end

   // block size memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_load) begin
         size_mem[slot_idx] <= SIZE_BITS'(req_amount);
      end
      if (rd_en) begin
         rd_q_ff <= size_mem[addr_ff];
      end
   end

   fppe_pick #(
      .BLOCKS    (BLOCKS),
      .SIZE_BITS (SIZE_BITS)
   ) u_pick (
      .clock     (clock),
      .reset     (reset),
      .ctl       (pick_ctl),
      .cand_pos  (eval_pos_ff),
      .cand_size (cand_size),
      .demand    (demand_ff),
      .found     (pick_found),
      .best_pos  (pick_pos),
      .best_size (pick_size)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_granted_ff;
   assign rsp_tdata  = {{(OUT_DATA_W - NUM_W - AMOUNT_W){1'b0}}, rsp_size_ff, rsp_num_ff};

endmodule

`default_nettype wire

@@ design/fppe_checker.sv @@
// port-level checker for the placement engine, bound to the top level
// depends on fppe_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_partition_placement_engine_unit_macros.svh"

module fppe_checker
   import fppe_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [KIND_W-1:0]     req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [OUT_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser
);

   logic req_xfer;
   logic req_is_place;
   assign req_xfer     = req_tvalid && req_tready;
   assign req_is_place = req_tuser == KIND_REQUEST;

   // stalled result holds its payload
   `FPPE_ASSERT_CLK(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // a refused or non-placement result carries no block
   `FPPE_ASSERT_CLK(a_refused_zero, rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0, "refused result carries data")

   // load, restart and unused kinds answer on the next cycle with no grant
   `FPPE_ASSERT_CLK(a_quick_answer, req_xfer && !req_is_place |=> rsp_tvalid && !rsp_tuser, "non-placement transfer not answered at once")

   // a placement request closes the input once accepted
   `FPPE_ASSERT_CLK(a_busy_scan, req_xfer && req_is_place |=> !req_tready, "input open during a scan")

   // nothing is presented right after reset
   `FPPE_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind fixed_partition_placement_engine_unit fppe_checker u_fppe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
